/* rtl/tdsd_pkg.sv */
// Shared types, request codes and segment table for the two-digit one-wire driver.
// No dependencies.
`timescale 1ns / 1ps

package tdsd_pkg;

  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_DEC    = 2'd1;
  localparam logic [1:0] REQ_HEX    = 2'd2;
  localparam logic [1:0] REQ_SINGLE = 2'd3;

  localparam logic [1:0] CFG_BIT_TIME    = 2'd0;
  localparam logic [1:0] CFG_STROBE_TIME = 2'd1;

  localparam logic [9:0] BIT_TIME_RST    = 10'd10;
  localparam logic [7:0] STROBE_TIME_RST = 8'd1;

  localparam logic [4:0] IDX_MINUS   = 5'd17;
  localparam logic [4:0] FRAME_PAIR  = 5'd16;
  localparam logic [4:0] FRAME_SINGLE = 5'd8;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [15:0] value;
    logic               blank_zero;
    logic               dot;
  } in_t;

  typedef struct packed {
    logic pin_level;
    logic busy_res;
    logic rejected;
  } out_t;

  typedef struct packed {
    logic [15:0] frame;
    logic [4:0]  len;
  } load_t;

  typedef struct packed {
    logic [9:0] bit_time;
    logic [7:0] strobe_time;
  } timing_t;

  function automatic logic [7:0] seg_code(input logic [4:0] idx);
    logic [7:0] c;
    case (idx)
      5'd0:    c = 8'hfa;
      5'd1:    c = 8'h18;
      5'd2:    c = 8'h76;
      5'd3:    c = 8'h3e;
      5'd4:    c = 8'h9c;
      5'd5:    c = 8'hae;
      5'd6:    c = 8'hee;
      5'd7:    c = 8'h38;
      5'd8:    c = 8'hfe;
      5'd9:    c = 8'hbe;
      5'd10:   c = 8'hfc;
      5'd11:   c = 8'hce;
      5'd12:   c = 8'h46;
      5'd13:   c = 8'h5e;
      5'd14:   c = 8'he6;
      5'd15:   c = 8'he4;
      5'd17:   c = 8'h04;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

/* rtl/tdsd_encode.sv */
// Frame encoder: turns a show request into segment-code frame and bit count.
// Depends on tdsd_pkg.
`timescale 1ns / 1ps

module tdsd_encode import tdsd_pkg::*; (
  input  in_t   req,
  output load_t load
);

  logic        neg;
  logic [7:0]  mag;
  logic [15:0] prod;
  logic [4:0]  quo;
  logic [7:0]  quo10;
  logic [7:0]  lo_w;
  logic [4:0]  hi_w;
  logic [4:0]  dec_hi;
  logic [4:0]  dec_lo;
  logic [15:0] raw;
  logic [7:0]  single_code;

  function automatic logic [7:0] digit(input logic [4:0] idx, input logic blank);
    return (blank && idx == 5'd0) ? 8'h00 : seg_code(idx);
  endfunction

  function automatic logic [15:0] pair(input logic [4:0] lo, input logic [4:0] hi,
                                       input logic blank);
    return {digit(hi, blank), digit(lo, blank && hi == 5'd0)};
  endfunction

  assign raw  = req.value;
  assign neg  = raw[15];
  assign mag  = neg ? (~raw[7:0] + 8'd1) : raw[7:0];

  // divide by ten: multiply by 205/2048, exact for 8-bit values
  assign prod  = {8'd0, mag} * 16'd205;
  assign quo   = prod[15:11];
  assign quo10 = {quo, 3'b000} + {2'b00, quo, 1'b0};
  assign lo_w  = mag - quo10;
  assign hi_w  = (quo >= 5'd20) ? quo - 5'd20 : ((quo >= 5'd10) ? quo - 5'd10 : quo);
  assign dec_lo = {1'b0, lo_w[3:0]};
  assign dec_hi = (neg && hi_w == 5'd0) ? IDX_MINUS : hi_w;

  always_comb begin
    if (req.blank_zero && raw == 16'd0) begin
      single_code = 8'h00;
    end else begin
      single_code = (raw <= 16'd17) ? seg_code(raw[4:0]) : 8'h00;
      single_code[0] = single_code[0] | req.dot;
    end
  end

  always_comb begin
    case (req.req_type)
      REQ_DEC: begin
        load.frame = pair(dec_lo, dec_hi, req.blank_zero);
        load.len   = FRAME_PAIR;
      end
      REQ_HEX: begin
        load.frame = pair({1'b0, raw[3:0]}, {1'b0, raw[7:4]}, req.blank_zero);
        load.len   = FRAME_PAIR;
      end
      default: begin
        load.frame = {8'h00, single_code};
        load.len   = FRAME_SINGLE;
      end
    endcase
  end

endmodule

/* rtl/tdsd_seq.sv */
// Pulse sequencer: frame shift register, bit and phase counters, pin level.
// Depends on tdsd_pkg.
`timescale 1ns / 1ps

module tdsd_seq import tdsd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step_en,
  input  logic [1:0] req_type,
  input  load_t   load,
  input  timing_t timing,
  output out_t    res
);

  logic [15:0] frame_r, frame_nxt;
  logic [4:0]  left_r, left_nxt;
  logic        strobe_r, strobe_nxt;
  logic [9:0]  phase_r, phase_nxt;
  logic        line_r, line_nxt;

  logic        busy;
  logic [9:0]  bit_ticks;
  logic [7:0]  strobe_ticks;
  logic [15:0] shifted;
  logic [4:0]  left_dec;

  assign busy         = left_r != 5'd0;
  assign bit_ticks    = (timing.bit_time == 10'd0) ? 10'd1 : timing.bit_time;
  assign strobe_ticks = (timing.strobe_time == 8'd0) ? 8'd1 : timing.strobe_time;
  assign shifted      = {1'b0, frame_r[15:1]};
  assign left_dec     = left_r - 5'd1;

  always_comb begin
    frame_nxt     = frame_r;
    left_nxt      = left_r;
    strobe_nxt    = strobe_r;
    phase_nxt     = phase_r;
    line_nxt      = line_r;
    res.pin_level = line_r;
    res.rejected  = 1'b0;
    if (req_type == REQ_TICK) begin
      if (busy) begin
        if (phase_r > 10'd1) begin
          phase_nxt = phase_r - 10'd1;
        end else if (!strobe_r && !frame_r[0]) begin
          strobe_nxt = 1'b1;
          phase_nxt  = {2'b00, strobe_ticks};
          line_nxt   = 1'b0;
        end else begin
          frame_nxt  = shifted;
          left_nxt   = left_dec;
          strobe_nxt = 1'b0;
          if (left_dec != 5'd0) begin
            phase_nxt = bit_ticks;
            line_nxt  = ~shifted[0];
          end else begin
            phase_nxt = 10'd0;
            line_nxt  = 1'b1;
          end
        end
      end
    end else if (busy) begin
      res.rejected = 1'b1;
    end else begin
      frame_nxt     = load.frame;
      left_nxt      = load.len;
      strobe_nxt    = 1'b0;
      phase_nxt     = bit_ticks;
      line_nxt      = ~load.frame[0];
      res.pin_level = ~load.frame[0];
    end
    res.busy_res = left_nxt != 5'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r  <= 16'd0;
      left_r   <= 5'd0;
      strobe_r <= 1'b0;
      phase_r  <= 10'd0;
      line_r   <= 1'b1;
    end else if (step_en) begin
      frame_r  <= frame_nxt;
      left_r   <= left_nxt;
      strobe_r <= strobe_nxt;
      phase_r  <= phase_nxt;
      line_r   <= line_nxt;
    end
  end

endmodule

/* rtl/two_digit_segment_one_wire_driver_unit.sv */
// Top level of the two-digit seven-segment one-wire display driver.
// Depends on tdsd_pkg, tdsd_encode and tdsd_seq.
`timescale 1ns / 1ps

// The result of each request (a one-microsecond tick or a show request) lands in the
// output register on the next edge; a new request is accepted every cycle while the output
// register is empty or being drained. Show requests build the frame in a single
// combinational pass (divide by ten by reciprocal multiply, table lookup); ticks step the
// bit and phase counters that shape the pulses on the pin. Timing registers must be
// written via the cfg port only while no request is in flight, unenforced by the block.
module two_digit_segment_one_wire_driver_unit import tdsd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_t       out_data,
  input  logic       cfg_we,
  input  logic [1:0] cfg_addr,
  input  logic [9:0] cfg_wdata
);

  timing_t timing_r;
  logic    out_valid_r, out_valid_nxt;
  out_t    out_data_r;
  logic    accept;
  load_t   load;
  out_t    res;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  tdsd_encode u_encode (
    .req  (in_data),
    .load (load)
  );

  tdsd_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (accept),
    .req_type (in_data.req_type),
    .load     (load),
    .timing   (timing_r),
    .res      (res)
  );

  always_comb begin
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timing_r.bit_time    <= BIT_TIME_RST;
      timing_r.strobe_time <= STROBE_TIME_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_BIT_TIME:    timing_r.bit_time    <= cfg_wdata;
        CFG_STROBE_TIME: timing_r.strobe_time <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

endmodule
